// ----- src/hil_pkg.sv -----
// Shared types and constants for the hinted interval lookup block.
// Holds the command and result word layouts, register indexes and sequencer states.
// Depends on nothing; the top level file of the block uses it by scoped names.
`default_nettype none

package hil_pkg;

    // Kinds of command word.
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Configuration port layout and register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 20;
    localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_LINE  = 1'b1;

    localparam int ENTRY_COUNT_W = 11;
    localparam int FIRST_LINE_W  = 20;

    // The binary search gives up after this many probes.
    localparam int MAX_PROBES = 19;
    localparam int PROBE_W    = 5;

    typedef struct packed {
        logic        kind;
        logic [9:0]  entry_slot;
        logic [15:0] entry_start;
        logic [15:0] entry_offset;
        logic        entry_step;
        logic [15:0] query_index;
        logic        hint_given;
        logic [9:0]  hint_slot;
    } in_word_t;

    typedef struct packed {
        logic [20:0] line_number;
        logic        step_point;
        logic [9:0]  found_slot;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HINT_A,
        S_HINT_B,
        S_HINT_C,
        S_SCAN_FIRST,
        S_SCAN,
        S_BS_MID,
        S_BS_LO,
        S_BS_HI,
        S_DONE
    } seq_state_t;

endpackage

`default_nettype wire

// ----- src/hil_table_ram.sv -----
// Single-port-write, single-port-read table memory with a registered read.
// Holds the interval entries of the hinted interval lookup block.
// Depends on nothing else.
`default_nettype none

module hil_table_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 33
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- src/hinted_interval_lookup_core.sv -----
// Top level of the hinted interval lookup block: sequencer, registers and result stage.
// Depends on hil_pkg for word layouts and states, and on hil_table_ram for the table.
//
// Channel   Signals                            Direction  Handshake
// command   start, busy, cmd (in_word_t)       in         taken when start && !busy
// result    done, result (out_word_t)          out        one-cycle strobe on done
// config    cfg_we, cfg_index, cfg_data        in         taken when cfg_we is high
//
// A write word goes straight into the table and the block stays ready. A lookup word
// keeps busy high while the sequencer walks the table through its single registered
// read port: it tries the hinted slot and the slots after it, scans from slot zero
// when the index is zero, and otherwise runs a binary search. The result word is
// registered and shows on done for one cycle while the next command can already be
// taken. The receiver cannot stall. Reset returns the sequencer to idle, clears done
// and the first line register and sets the entry count to one; the table contents
// stay undefined until written.
`default_nettype none

module hinted_interval_lookup_core #(
    parameter int TABLE_DEPTH = 1024,
    parameter int INDEX_BITS  = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire hil_pkg::in_word_t                  cmd,
    output logic                                    done,
    output hil_pkg::out_word_t                      result,
    input  wire logic                               cfg_we,
    input  wire logic [hil_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [hil_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Starts are compared in their low KEY_BITS bits, INDEX_BITS capped at 16; the fields carry 16.
    localparam int KEY_BITS = (INDEX_BITS < 16) ? INDEX_BITS : 16;
    localparam int ENTRY_W  = KEY_BITS + 17;
    localparam int AW       = $clog2(TABLE_DEPTH);
    localparam int CW       = $clog2(TABLE_DEPTH + 1);
    localparam int CX       = CW + 1;

    // Registers.
    hil_pkg::seq_state_t                 state_reg, state_next;
    logic [hil_pkg::ENTRY_COUNT_W-1:0]   entry_count_reg;
    logic [hil_pkg::FIRST_LINE_W-1:0]    first_line_reg;
    logic                                done_reg, done_next;
    hil_pkg::out_word_t                  result_reg, result_next;
    logic [KEY_BITS-1:0]                 idx_reg, idx_next;
    logic [CW-1:0]                       n_reg, n_next;
    logic [AW-1:0]                       hint_reg, hint_next;
    logic [KEY_BITS-1:0]                 prev_reg, prev_next;
    logic [AW-1:0]                       scan_reg, scan_next;
    logic [CW-1:0]                       low_reg, low_next;
    logic [CW-1:0]                       hi1_reg, hi1_next;
    logic [AW-1:0]                       mid_reg, mid_next;
    logic [AW-1:0]                       pos_reg, pos_next;
    logic [hil_pkg::PROBE_W-1:0]         probe_reg, probe_next;

    // Table port.
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [ENTRY_W-1:0]   mem_wdata;
    logic [AW-1:0]        rd_addr;
    logic [ENTRY_W-1:0]   rd_data;

    // Decisions shared by the next-state and datapath blocks.
    logic                 accept;
    logic                 accept_lookup;
    logic [CW-1:0]        n_clamped;
    logic                 hint_ok;
    logic [KEY_BITS-1:0]  rd_start;
    logic                 ge_rd;
    logic                 ge_prev;
    logic                 cover_rd;
    logic                 idx_zero;
    logic                 h2_in;
    logic                 scan_more;
    logic                 mid1_in;
    logic                 bs_go;
    logic [CX-1:0]        mid_sum;
    logic [AW-1:0]        mid_calc;

    assign busy   = (state_reg != hil_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign accept        = start && !busy;
    assign accept_lookup = accept && (cmd.kind == hil_pkg::KIND_LOOKUP);

    // Write words go straight into the table; slots past the depth are dropped.
    assign mem_we    = accept && (cmd.kind == hil_pkg::KIND_WRITE)
                       && (32'(cmd.entry_slot) < TABLE_DEPTH);
    assign mem_waddr = AW'(cmd.entry_slot);
    assign mem_wdata = {cmd.entry_step, cmd.entry_offset, cmd.entry_start[KEY_BITS-1:0]};

    hil_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Entry count in use: zero acts as one, large values saturate at the depth.
    always_comb
    begin
        priority if (entry_count_reg == '0)
        begin
            n_clamped = CW'(1);
        end
        else if (32'(entry_count_reg) > TABLE_DEPTH)
        begin
            n_clamped = CW'(TABLE_DEPTH);
        end
        else
        begin
            n_clamped = CW'(entry_count_reg);
        end
    end

    // One compare against the word just read and one against the word held from the
    // previous read decide every step. With index zero the scan test "start is zero
    // and the next start is not" is the same interval test.
    always_comb
    begin
        hint_ok   = cmd.hint_given && ((32'(cmd.hint_slot) + 32'd1) < 32'(n_clamped));
        rd_start  = rd_data[KEY_BITS-1:0];
        ge_rd     = (idx_reg >= rd_start);
        ge_prev   = (idx_reg >= prev_reg);
        cover_rd  = ge_prev && !ge_rd;
        idx_zero  = (idx_reg == '0);
        h2_in     = (CX'(hint_reg) + CX'(2)) < CX'(n_reg);
        scan_more = (CX'(scan_reg) + CX'(2)) < CX'(n_reg);
        mid1_in   = (CX'(mid_reg) + CX'(1)) < CX'(n_reg);
        bs_go     = (hi1_reg > low_reg) && (32'(probe_reg) < hil_pkg::MAX_PROBES);
        mid_sum   = CX'(low_reg) + CX'(hi1_reg) - CX'(1);
        mid_calc  = AW'(mid_sum >> 1);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hil_pkg::S_IDLE:
            begin
                if (accept_lookup)
                begin
                    state_next = hint_ok ? hil_pkg::S_HINT_A : hil_pkg::S_BS_MID;
                end
            end
            hil_pkg::S_HINT_A:
            begin
                state_next = hil_pkg::S_HINT_B;
            end
            hil_pkg::S_HINT_B:
            begin
                priority if (cover_rd)
                begin
                    state_next = hil_pkg::S_DONE;
                end
                else if (h2_in)
                begin
                    state_next = hil_pkg::S_HINT_C;
                end
                else if (ge_rd)
                begin
                    state_next = hil_pkg::S_DONE;
                end
                else if (idx_zero)
                begin
                    state_next = hil_pkg::S_SCAN_FIRST;
                end
                else
                begin
                    state_next = hil_pkg::S_BS_MID;
                end
            end
            hil_pkg::S_HINT_C:
            begin
                priority if (cover_rd)
                begin
                    state_next = hil_pkg::S_DONE;
                end
                else if (idx_zero)
                begin
                    state_next = hil_pkg::S_SCAN_FIRST;
                end
                else
                begin
                    state_next = hil_pkg::S_BS_MID;
                end
            end
            hil_pkg::S_SCAN_FIRST:
            begin
                state_next = hil_pkg::S_SCAN;
            end
            hil_pkg::S_SCAN:
            begin
                priority if (cover_rd)
                begin
                    state_next = hil_pkg::S_DONE;
                end
                else if (scan_more)
                begin
                    state_next = hil_pkg::S_SCAN;
                end
                else
                begin
                    state_next = hil_pkg::S_BS_MID;
                end
            end
            hil_pkg::S_BS_MID:
            begin
                state_next = bs_go ? hil_pkg::S_BS_LO : hil_pkg::S_DONE;
            end
            hil_pkg::S_BS_LO:
            begin
                priority if (!ge_rd)
                begin
                    state_next = hil_pkg::S_BS_MID;
                end
                else if (mid1_in)
                begin
                    state_next = hil_pkg::S_BS_HI;
                end
                else
                begin
                    state_next = hil_pkg::S_DONE;
                end
            end
            hil_pkg::S_BS_HI:
            begin
                state_next = ge_rd ? hil_pkg::S_BS_MID : hil_pkg::S_DONE;
            end
            hil_pkg::S_DONE:
            begin
                state_next = hil_pkg::S_IDLE;
            end
            default:
            begin
                state_next = hil_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, read address and result. Whenever an entry is settled its position is
    // put on the read port, so its word is at hand in the done state.
    always_comb
    begin
        idx_next   = idx_reg;
        n_next     = n_reg;
        hint_next  = hint_reg;
        prev_next  = prev_reg;
        scan_next  = scan_reg;
        low_next   = low_reg;
        hi1_next   = hi1_reg;
        mid_next   = mid_reg;
        pos_next   = pos_reg;
        probe_next = probe_reg;
        rd_addr    = pos_reg;
        done_next  = 1'b0;
        result_next = result_reg;

        unique case (state_reg)
            hil_pkg::S_IDLE:
            begin
                rd_addr = AW'(cmd.hint_slot);
                if (accept_lookup)
                begin
                    idx_next   = cmd.query_index[KEY_BITS-1:0];
                    n_next     = n_clamped;
                    hint_next  = AW'(cmd.hint_slot);
                    low_next   = '0;
                    hi1_next   = n_clamped;
                    probe_next = '0;
                end
            end
            hil_pkg::S_HINT_A:
            begin
                prev_next = rd_start;
                rd_addr   = hint_reg + AW'(1);
            end
            hil_pkg::S_HINT_B:
            begin
                priority if (cover_rd)
                begin
                    pos_next = hint_reg;
                    rd_addr  = hint_reg;
                end
                else if (h2_in)
                begin
                    prev_next = rd_start;
                    rd_addr   = hint_reg + AW'(2);
                end
                else if (ge_rd)
                begin
                    // The successor is the last entry and has no upper bound.
                    pos_next = hint_reg + AW'(1);
                    rd_addr  = hint_reg + AW'(1);
                end
                else
                begin
                    scan_next = '0;
                    rd_addr   = '0;
                end
            end
            hil_pkg::S_HINT_C:
            begin
                if (cover_rd)
                begin
                    pos_next = hint_reg + AW'(1);
                    rd_addr  = hint_reg + AW'(1);
                end
                else
                begin
                    scan_next = '0;
                    rd_addr   = '0;
                end
            end
            hil_pkg::S_SCAN_FIRST:
            begin
                prev_next = rd_start;
                rd_addr   = AW'(1);
            end
            hil_pkg::S_SCAN:
            begin
                priority if (cover_rd)
                begin
                    pos_next = scan_reg;
                    rd_addr  = scan_reg;
                end
                else if (scan_more)
                begin
                    prev_next = rd_start;
                    scan_next = scan_reg + AW'(1);
                    rd_addr   = scan_reg + AW'(2);
                end
                else
                begin
                    rd_addr = scan_reg;
                end
            end
            hil_pkg::S_BS_MID:
            begin
                if (bs_go)
                begin
                    mid_next   = mid_calc;
                    probe_next = probe_reg + hil_pkg::PROBE_W'(1);
                    rd_addr    = mid_calc;
                end
                else
                begin
                    // Nothing found: fall back to the last entry in use.
                    pos_next = AW'(n_reg - CW'(1));
                    rd_addr  = AW'(n_reg - CW'(1));
                end
            end
            hil_pkg::S_BS_LO:
            begin
                priority if (!ge_rd)
                begin
                    hi1_next = CW'(mid_reg);
                end
                else if (mid1_in)
                begin
                    rd_addr = mid_reg + AW'(1);
                end
                else
                begin
                    pos_next = mid_reg;
                    rd_addr  = mid_reg;
                end
            end
            hil_pkg::S_BS_HI:
            begin
                if (ge_rd)
                begin
                    low_next = CW'(mid_reg) + CW'(1);
                end
                else
                begin
                    pos_next = mid_reg;
                    rd_addr  = mid_reg;
                end
            end
            hil_pkg::S_DONE:
            begin
                done_next               = 1'b1;
                result_next.line_number = 21'(rd_data[KEY_BITS +: 16]) + 21'(first_line_reg);
                result_next.step_point  = rd_data[KEY_BITS + 16];
                result_next.found_slot  = 10'(pos_reg);
            end
            default:
            begin
                rd_addr = pos_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= hil_pkg::S_IDLE;
            done_reg        <= 1'b0;
            entry_count_reg <= hil_pkg::ENTRY_COUNT_W'(1);
            first_line_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    hil_pkg::REG_ENTRY_COUNT:
                    begin
                        entry_count_reg <= cfg_data[hil_pkg::ENTRY_COUNT_W-1:0];
                    end
                    hil_pkg::REG_FIRST_LINE:
                    begin
                        first_line_reg <= cfg_data[hil_pkg::FIRST_LINE_W-1:0];
                    end
                    default:
                    begin
                        first_line_reg <= first_line_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        idx_reg    <= idx_next;
        n_reg      <= n_next;
        hint_reg   <= hint_next;
        prev_reg   <= prev_next;
        scan_reg   <= scan_next;
        low_reg    <= low_next;
        hi1_reg    <= hi1_next;
        mid_reg    <= mid_next;
        pos_reg    <= pos_next;
        probe_reg  <= probe_next;
    end

    // A result strobe only follows the done state.
    a_done_after_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == hil_pkg::S_DONE))
        else $error("result strobe without a finished lookup");

    // The reported position always lies inside the entries in use.
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hil_pkg::S_DONE) |-> (CX'(pos_reg) < CX'(n_reg)))
        else $error("found position outside the table in use");

    // The search window never reaches past the entries in use.
    a_window_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hil_pkg::S_BS_MID) |-> (hi1_reg <= n_reg && low_reg <= n_reg))
        else $error("binary search window out of bounds");

    // A write word leaves the sequencer idle.
    a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.kind == hil_pkg::KIND_WRITE) |=> (state_reg == hil_pkg::S_IDLE))
        else $error("write word started the sequencer");

endmodule

`default_nettype wire
